>>> src/wwrf_pkg.sv
// Shared types, constants and register codes for the widest white run finder.
// Used by every module in src; depends on nothing else.
`timescale 1ns / 1ps

package wwrf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int LEN_CAP  = (MAX_COLS < 2047) ? MAX_COLS : 2047;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd0;
  localparam logic [2:0] CFG_WINDOW_ROWS  = 3'd1;
  localparam logic [2:0] CFG_RED_MIN      = 3'd2;
  localparam logic [2:0] CFG_GREEN_MIN    = 3'd3;
  localparam logic [2:0] CFG_BLUE_MIN     = 3'd4;
  localparam logic [2:0] CFG_TINT_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_MIN_RUN      = 3'd6;

  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd120;
  localparam logic [10:0] RST_WINDOW_ROWS  = 11'd80;
  localparam logic [7:0]  RST_CHAN_MIN     = 8'd100;
  localparam logic [8:0]  RST_TINT_LIMIT   = 9'd45;
  localparam logic [10:0] RST_MIN_RUN      = 11'd3;

  typedef struct packed {
    logic [10:0] image_height;
    logic [10:0] window_rows;
    logic [7:0]  red_min;
    logic [7:0]  green_min;
    logic [7:0]  blue_min;
    logic [8:0]  tint_limit;
    logic [10:0] min_run;
  } cfg_t;

  typedef struct packed {
    logic       white;
    logic [9:0] col;
    logic [9:0] row;
    logic       row_end;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  center_col;
    logic [9:0]  best_row;
    logic [10:0] run_width;
  } res_t;

endpackage

>>> src/wwrf_front.sv
// Front end: accepts pixels and classifies each as white inside the scan window.
// Depends on wwrf_pkg; feeds wwrf_fifo.
`timescale 1ns / 1ps

module wwrf_front import wwrf_pkg::*; (
  input  cfg_t       cfg_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [9:0] col_i,
  input  logic [9:0] row_i,
  input  logic       row_end_i,
  input  logic       frame_end_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output pix_t       q_data_o
);

  logic [10:0] height;
  logic [11:0] row_sum;
  logic        in_window;
  logic [7:0]  diff_rg;
  logic [7:0]  diff_rb;
  logic        white;

  always_comb begin
    height = (cfg_i.image_height > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : cfg_i.image_height;
    row_sum = {2'b00, row_i} + {1'b0, cfg_i.window_rows};
    in_window = ({1'b0, row_i} < height) && (row_sum >= {1'b0, height});
    diff_rg = (red_i > green_i) ? (red_i - green_i) : (green_i - red_i);
    diff_rb = (red_i > blue_i) ? (red_i - blue_i) : (blue_i - red_i);
    white = in_window && (red_i > cfg_i.red_min) && (green_i > cfg_i.green_min) &&
            (blue_i > cfg_i.blue_min) && ({1'b0, diff_rg} < cfg_i.tint_limit) &&
            ({1'b0, diff_rb} < cfg_i.tint_limit);
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  always_comb begin
    q_data_o.white     = white;
    q_data_o.col       = col_i;
    q_data_o.row       = row_i;
    q_data_o.row_end   = row_end_i;
    q_data_o.frame_end = frame_end_i;
  end

endmodule

>>> src/wwrf_fifo.sv
// Short queue of classified pixels between the front and back ends.
// Depends on wwrf_pkg for the entry type and depth.
`timescale 1ns / 1ps

module wwrf_fifo import wwrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t din_i,
  output logic full_o,
  input  logic pop_i,
  output pix_t dout_o,
  output logic empty_o
);

  pix_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

>>> src/wwrf_back.sv
// Back end: tracks horizontal white runs, keeps the widest one and holds the frame result.
// Depends on wwrf_pkg; drains wwrf_fifo.
`timescale 1ns / 1ps

module wwrf_back import wwrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [10:0] min_run_i,
  input  logic        q_empty_i,
  input  pix_t        q_data_i,
  output logic        q_pop_o,
  input  logic        res_pop_i,
  output logic        res_empty_o,
  output res_t        res_o
);

  logic        in_run_q, in_run_d;
  logic [9:0]  run_start_q, run_start_d;
  logic [10:0] run_len_q, run_len_d;
  logic [10:0] best_len_q, best_len_d;
  logic [9:0]  best_center_q, best_center_d;
  logic [9:0]  best_row_q, best_row_d;
  logic        res_valid_q, res_valid_d;
  res_t        res_q, res_d;

  logic        take;
  logic [10:0] len_base;
  logic [10:0] len_grow;
  logic [9:0]  cl_start;
  logic [10:0] cl_len;
  logic        cl_en;
  logic        better;
  logic [10:0] center_sum;
  logic [10:0] nb_len;
  logic [9:0]  nb_center;
  logic [9:0]  nb_row;

  always_comb begin
    take = !q_empty_i && (!q_data_i.frame_end || !res_valid_q || res_pop_i);
    len_base = in_run_q ? run_len_q : '0;
    len_grow = (len_base < 11'(LEN_CAP)) ? len_base + 1'b1 : len_base;
    if (q_data_i.white) begin
      cl_start = in_run_q ? run_start_q : q_data_i.col;
      cl_len   = len_grow;
      cl_en    = q_data_i.row_end || q_data_i.frame_end;
    end else begin
      cl_start = run_start_q;
      cl_len   = run_len_q;
      cl_en    = in_run_q;
    end
    better = cl_en && (cl_len >= min_run_i) &&
             ((cl_len > best_len_q) ||
              ((cl_len == best_len_q) && (best_len_q != '0) && (q_data_i.row > best_row_q)));
    center_sum = {1'b0, cl_start} + (cl_len >> 1);
    nb_len    = better ? cl_len : best_len_q;
    nb_center = better ? center_sum[9:0] : best_center_q;
    nb_row    = better ? q_data_i.row : best_row_q;
  end

  always_comb begin
    in_run_d      = in_run_q;
    run_start_d   = run_start_q;
    run_len_d     = run_len_q;
    best_len_d    = best_len_q;
    best_center_d = best_center_q;
    best_row_d    = best_row_q;
    res_valid_d   = res_valid_q;
    res_d         = res_q;
    if (res_pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    if (take) begin
      if (cl_en) begin
        in_run_d    = 1'b0;
        run_start_d = '0;
        run_len_d   = '0;
      end else if (q_data_i.white) begin
        in_run_d    = 1'b1;
        run_start_d = cl_start;
        run_len_d   = len_grow;
      end
      if (q_data_i.frame_end) begin
        best_len_d       = '0;
        best_center_d    = '0;
        best_row_d       = '0;
        res_valid_d      = 1'b1;
        res_d.found      = (nb_len != '0);
        res_d.center_col = (nb_len != '0) ? nb_center : '0;
        res_d.best_row   = (nb_len != '0) ? nb_row : '0;
        res_d.run_width  = nb_len;
      end else begin
        best_len_d    = nb_len;
        best_center_d = nb_center;
        best_row_d    = nb_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q      <= 1'b0;
      run_start_q   <= '0;
      run_len_q     <= '0;
      best_len_q    <= '0;
      best_center_q <= '0;
      best_row_q    <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      in_run_q      <= in_run_d;
      run_start_q   <= run_start_d;
      run_len_q     <= run_len_d;
      best_len_q    <= best_len_d;
      best_center_q <= best_center_d;
      best_row_q    <= best_row_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign q_pop_o     = take;
  assign res_empty_o = !res_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/widest_white_run_finder_top.sv
// Top level of the widest white run finder: configuration registers and wiring.
// Depends on wwrf_pkg, wwrf_front, wwrf_fifo and wwrf_back.
`timescale 1ns / 1ps

// The block takes one pixel item per clock in raster order while full is low and, on
// the last pixel of a frame, offers one result item: whether a white run of at least
// min_run pixels was seen, and the center column, row and width of the widest one.
// Pixels are classified as they are pushed and pass through a four-entry queue to the
// run tracker, which retires one item per cycle unless a frame-end item must wait for
// the result register, and registers each frame result when it takes the frame-end
// item. The single result register holds one frame result, so a following frame-end
// item waits in the queue until that result is popped, and full rises once the queue
// fills behind it. Configuration writes take effect at once and belong between frames.

module widest_white_run_finder_top import wwrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [9:0]  col_i,
  input  logic [9:0]  row_i,
  input  logic        row_end_i,
  input  logic        frame_end_i,
  input  logic        pop,
  output logic        empty,
  output logic        found_o,
  output logic [9:0]  center_col_o,
  output logic [9:0]  best_row_o,
  output logic [10:0] run_width_o
);

  cfg_t cfg_q, cfg_d;
  logic q_push;
  pix_t q_din;
  logic q_full;
  logic q_pop;
  pix_t q_dout;
  logic q_empty;
  res_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_HEIGHT: cfg_d.image_height = cfg_wdata_i;
        CFG_WINDOW_ROWS:  cfg_d.window_rows  = cfg_wdata_i;
        CFG_RED_MIN:      cfg_d.red_min      = cfg_wdata_i[7:0];
        CFG_GREEN_MIN:    cfg_d.green_min    = cfg_wdata_i[7:0];
        CFG_BLUE_MIN:     cfg_d.blue_min     = cfg_wdata_i[7:0];
        CFG_TINT_LIMIT:   cfg_d.tint_limit   = cfg_wdata_i[8:0];
        CFG_MIN_RUN:      cfg_d.min_run      = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_height <= RST_IMAGE_HEIGHT;
      cfg_q.window_rows  <= RST_WINDOW_ROWS;
      cfg_q.red_min      <= RST_CHAN_MIN;
      cfg_q.green_min    <= RST_CHAN_MIN;
      cfg_q.blue_min     <= RST_CHAN_MIN;
      cfg_q.tint_limit   <= RST_TINT_LIMIT;
      cfg_q.min_run      <= RST_MIN_RUN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wwrf_front u_front (
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .row_end_i   (row_end_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_din)
  );

  wwrf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty)
  );

  wwrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_run_i   (cfg_q.min_run),
    .q_empty_i   (q_empty),
    .q_data_i    (q_dout),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign found_o      = res.found;
  assign center_col_o = res.center_col;
  assign best_row_o   = res.best_row;
  assign run_width_o  = res.run_width;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for widest_white_run_finder_top: pixel items in, frame results out.
// Depends on wwrf_pkg and the top level; a run tracker predicts each untyped frame result.
`timescale 1ns / 1ps

module testbench import wwrf_pkg::*;;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1060;
  localparam int HOLD_CYCLES   = 400;
  localparam int DIR_ROWS      = 21;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] col;
    logic [9:0] row;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    pixel_t px;
    logic   typed;
    res_t   want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{8'd0,   8'd0,   8'd0,   10'd0,    10'd0,   1'b0, 1'b1}, 1'b1,
      '{1'b0, 10'd0, 10'd0, 11'd0}},
    '{'{8'd255, 8'd255, 8'd255, 10'd1023, 10'd119, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 10'd0,    10'd119, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 10'd1,    10'd119, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd0,   10'd2,    10'd119, 1'b0, 1'b1}, 1'b1,
      '{1'b1, 10'd0, 10'd119, 11'd3}},
    '{'{8'd101, 8'd101, 8'd101, 10'd5,    10'd40,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd200, 8'd156, 8'd200, 10'd6,    10'd40,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd200, 8'd200, 8'd156, 10'd7,    10'd40,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd200, 8'd155, 8'd200, 10'd8,    10'd40,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd0,    10'd39,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd0,    10'd120, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd10,   10'd50,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd11,   10'd50,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd12,   10'd50,  1'b1, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd20,   10'd50,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd21,   10'd50,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd22,   10'd50,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd100, 8'd200, 8'd200, 10'd23,   10'd50,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd0,    10'd60,  1'b0, 1'b0}, 1'b0, '0},
    '{'{8'd150, 8'd150, 8'd150, 10'd1,    10'd60,  1'b0, 1'b1}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd255, 10'd3,    10'd70,  1'b0, 1'b1}, 1'b1,
      '{1'b0, 10'd0, 10'd0, 11'd0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [10:0] cfg_wdata_i;
  logic        push;
  logic        full;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic [9:0]  col_i;
  logic [9:0]  row_i;
  logic        row_end_i;
  logic        frame_end_i;
  logic        pop;
  logic        empty;
  logic        found_o;
  logic [9:0]  center_col_o;
  logic [9:0]  best_row_o;
  logic [10:0] run_width_o;

  widest_white_run_finder_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .row_end_i    (row_end_i),
    .frame_end_i  (frame_end_i),
    .pop          (pop),
    .empty        (empty),
    .found_o      (found_o),
    .center_col_o (center_col_o),
    .best_row_o   (best_row_o),
    .run_width_o  (run_width_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Tracker state and the register copy it runs on.
  cfg_t        cur_cfg = '{RST_IMAGE_HEIGHT, RST_WINDOW_ROWS, RST_CHAN_MIN, RST_CHAN_MIN,
                           RST_CHAN_MIN, RST_TINT_LIMIT, RST_MIN_RUN};
  logic        run_open = 1'b0;
  logic [9:0]  run_start = '0;
  logic [10:0] run_len = '0;
  logic [10:0] best_len = '0;
  logic [9:0]  best_center = '0;
  logic [9:0]  best_row = '0;

  res_t frame_results_due [$];

  int fail_count      = 0;
  int items_sent      = 0;
  int rand_items      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int full_stalls     = 0;
  int widest_seen     = 0;
  int cycles          = 0;
  int send_idle_pct   = 16;
  int recv_idle_pct   = 79;
  bit hold_request    = 1'b0;

  function automatic int channel_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic close_run(input logic [9:0] row);
    if (run_open) begin
      if (run_len >= cur_cfg.min_run &&
          (run_len > best_len || (run_len == best_len && best_len != 0 && row > best_row))) begin
        best_len    = run_len;
        best_center = run_start + 10'(run_len >> 1);
        best_row    = row;
      end
      run_open  = 1'b0;
      run_start = '0;
      run_len   = '0;
    end
  endtask

  task automatic track_pixel(input pixel_t p, output logic has_res, output res_t r);
    int  h;
    bit  in_win;
    bit  white;
    h      = (cur_cfg.image_height > MAX_ROWS) ? MAX_ROWS : int'(cur_cfg.image_height);
    in_win = (int'(p.row) < h) && (int'(p.row) + int'(cur_cfg.window_rows) >= h);
    white  = p.red > cur_cfg.red_min && p.green > cur_cfg.green_min &&
             p.blue > cur_cfg.blue_min &&
             channel_gap(p.red, p.green) < int'(cur_cfg.tint_limit) &&
             channel_gap(p.red, p.blue) < int'(cur_cfg.tint_limit);
    if (in_win && white) begin
      if (!run_open) begin
        run_open  = 1'b1;
        run_start = p.col;
        run_len   = '0;
      end
      if (run_len < LEN_CAP) run_len++;
    end else begin
      close_run(p.row);
    end
    if (p.row_end || p.frame_end) close_run(p.row);
    has_res = p.frame_end;
    r       = '0;
    if (p.frame_end) begin
      r.found      = (best_len != 0);
      r.center_col = (best_len != 0) ? best_center : 10'd0;
      r.best_row   = (best_len != 0) ? best_row : 10'd0;
      r.run_width  = best_len;
      run_open    = 1'b0;
      run_start   = '0;
      run_len     = '0;
      best_len    = '0;
      best_center = '0;
      best_row    = '0;
    end
  endtask

  task automatic send_pixel(input pixel_t p, output logic has_res, output res_t r);
    if (items_sent < 420) begin
      send_idle_pct = 16;
      recv_idle_pct = 79;
    end else if (items_sent < 840) begin
      send_idle_pct = 79;
      recv_idle_pct = 16;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    red_i       <= p.red;
    green_i     <= p.green;
    blue_i      <= p.blue;
    col_i       <= p.col;
    row_i       <= p.row;
    row_end_i   <= p.row_end;
    frame_end_i <= p.frame_end;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    items_sent++;
    track_pixel(p, has_res, r);
  endtask

  task automatic feed_pixel(input pixel_t p);
    logic has_res;
    res_t r;
    send_pixel(p, has_res, r);
    if (has_res) frame_results_due.push_back(r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    push <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_IMAGE_HEIGHT, c.image_height);
    write_reg(CFG_WINDOW_ROWS, c.window_rows);
    write_reg(CFG_RED_MIN, c.red_min);
    write_reg(CFG_GREEN_MIN, c.green_min);
    write_reg(CFG_BLUE_MIN, c.blue_min);
    write_reg(CFG_TINT_LIMIT, c.tint_limit);
    write_reg(CFG_MIN_RUN, c.min_run);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) c.image_height = 11'($urandom_range(1, 12));
    else if (sel == 7) c.image_height = 11'd0;
    else if (sel == 8) c.image_height = 11'd1024;
    else c.image_height = 11'($urandom_range(1025, 2047));
    if ($urandom_range(0, 9) < 4) c.window_rows = 11'($urandom_range(0, 6));
    else if ($urandom_range(0, 9) == 0) c.window_rows = 11'd2047;
    else c.window_rows = 11'($urandom_range(0, int'(c.image_height) + 2));
    c.red_min    = 8'($urandom_range(0, 200));
    c.green_min  = 8'($urandom_range(0, 200));
    c.blue_min   = 8'($urandom_range(0, 200));
    c.tint_limit = 9'($urandom_range(1, 300));
    c.min_run    = 11'($urandom_range(0, 5));
    return c;
  endfunction

  function automatic pixel_t paint(input pixel_t p);
    int lo;
    int v;
    int w;
    lo = cur_cfg.red_min;
    if (cur_cfg.green_min > lo) lo = cur_cfg.green_min;
    if (cur_cfg.blue_min > lo) lo = cur_cfg.blue_min;
    lo = (lo >= 255) ? 255 : lo + 1;
    if ($urandom_range(0, 99) < 78) begin
      v       = $urandom_range(lo, 255);
      p.red   = 8'(v);
      p.green = 8'(v);
      p.blue  = 8'(v);
      if ($urandom_range(0, 2) == 0) begin
        w = v + int'($urandom_range(0, 40)) - 20;
        p.green = (w < 0) ? 8'd0 : (w > 255) ? 8'd255 : 8'(w);
      end
      if ($urandom_range(0, 2) == 0) begin
        w = v + int'($urandom_range(0, 40)) - 20;
        p.blue = (w < 0) ? 8'd0 : (w > 255) ? 8'd255 : 8'(w);
      end
    end else begin
      p.red   = 8'($urandom);
      p.green = 8'($urandom);
      p.blue  = 8'($urandom);
    end
    return p;
  endfunction

  task automatic send_frame(output int count);
    int     nrows;
    int     ncols;
    int     h;
    int     r0;
    int     c0;
    int     sel;
    pixel_t p;
    nrows = $urandom_range(1, 6);
    ncols = $urandom_range(1, 14);
    h     = (cur_cfg.image_height > MAX_ROWS) ? MAX_ROWS : int'(cur_cfg.image_height);
    r0    = h - nrows + int'($urandom_range(0, 3)) - 1;
    if (r0 > 1024 - nrows) r0 = 1024 - nrows;
    if (r0 < 0) r0 = 0;
    sel = $urandom_range(0, 9);
    if (sel < 5) c0 = 0;
    else if (sel < 8) c0 = $urandom_range(0, 1023);
    else c0 = $urandom_range(1014, 1023);
    for (int rr = 0; rr < nrows; rr++) begin
      for (int cc = 0; cc < ncols; cc++) begin
        p           = '0;
        p.col       = 10'(c0 + cc);
        p.row       = 10'(r0 + rr);
        p.row_end   = (cc == ncols - 1);
        p.frame_end = (rr == nrows - 1) && (cc == ncols - 1);
        feed_pixel(paint(p));
      end
    end
    count = nrows * ncols;
  endtask

  task automatic random_traffic(input int n);
    int     sent;
    int     k;
    pixel_t p;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 8) begin
        p.red       = 8'($urandom);
        p.green     = 8'($urandom);
        p.blue      = 8'($urandom);
        p.col       = 10'($urandom);
        p.row       = 10'($urandom);
        p.row_end   = 1'($urandom);
        p.frame_end = ($urandom_range(0, 7) == 0);
        feed_pixel(p);
        sent++;
      end else begin
        send_frame(k);
        sent += k;
      end
    end
    send_frame(k);
    rand_items += sent + k;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL widest_white_run_finder_top");
      $finish;
    end
  end

  initial begin : result_side
    res_t want;
    int   hold;
    bit   held;
    pop  <= 1'b0;
    hold = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        results_checked++;
        if (run_width_o > widest_seen) widest_seen = run_width_o;
        if (frame_results_due.size() == 0) begin
          $error("frame result with no frame end pending");
          fail_count++;
        end else begin
          want = frame_results_due.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_o);
            fail_count++;
          end
          if (center_col_o !== want.center_col) begin
            $error("center_col: expected %0d, got %0d", want.center_col, center_col_o);
            fail_count++;
          end
          if (best_row_o !== want.best_row) begin
            $error("best_row: expected %0d, got %0d", want.best_row, best_row_o);
            fail_count++;
          end
          if (run_width_o !== want.run_width) begin
            $error("run_width: expected %0d, got %0d", want.run_width, run_width_o);
            fail_count++;
          end
        end
      end
      if (hold_request && !held) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic   has_res;
    res_t   r;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    red_i       <= '0;
    green_i     <= '0;
    blue_i      <= '0;
    col_i       <= '0;
    row_i       <= '0;
    row_end_i   <= 1'b0;
    frame_end_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_pixel(DIR_TAB[i].px, has_res, r);
      if (has_res) frame_results_due.push_back(DIR_TAB[i].typed ? DIR_TAB[i].want : r);
    end

    // Register extremes: nothing in the window, nothing white, a single row, full height.
    load_config('{11'd0, 11'd1024, 8'd0, 8'd0, 8'd0, 9'd256, 11'd1});
    random_traffic(40);
    load_config('{11'd2047, 11'd2047, 8'd255, 8'd255, 8'd255, 9'd511, 11'd2047});
    random_traffic(40);
    load_config('{11'd1, 11'd1, 8'd0, 8'd0, 8'd0, 9'd256, 11'd0});
    random_traffic(40);
    load_config('{11'd1024, 11'd1024, 8'd0, 8'd0, 8'd0, 9'd1, 11'd1});
    random_traffic(40);

    load_config(random_cfg());
    hold_request = 1'b1;
    random_traffic(110);
    while (rand_items < RANDOM_ITEMS) begin
      load_config(random_cfg());
      random_traffic(110);
    end

    push <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixel items under %0d register settings; checked %0d frame results.",
             items_sent, settings_used, results_checked);
    $display("Input held off by full for %0d cycles; widest run reported was %0d pixels.",
             full_stalls, widest_seen);
    if (fail_count == 0) begin
      $display("PASS widest_white_run_finder_top");
    end else begin
      $display("FAIL widest_white_run_finder_top");
    end
    $finish;
  end

endmodule
